// ===== src/cbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbpe_pkg
// shared constants, field layout and queue entry types of the cubic
// bezier point evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package cbpe_pkg;

    // coordinate format, signed Q16.16
    localparam int COORD_W    = 32;
    localparam int NUM_AXES   = 3;
    localparam int NUM_POINTS = 4;
    localparam int IDX_W      = 2;

    // curve parameter, Q0.16 with one extra bit so that 1.0 fits
    localparam int            U_W   = 17;
    localparam logic [U_W-1:0] U_ONE = 17'h10000;
    localparam int            U3_W  = 18;  // 3 * u still fits
    localparam int            SQ_W  = 33;  // u * u up to 2^32

    // weights in units of 2^-48, split into two partial products
    localparam int FRAC_SHIFT = 48;
    localparam int WEIGHT_W   = 49;
    localparam int W_LO_W     = 24;
    localparam int W_HI_W     = WEIGHT_W - W_LO_W;
    localparam int LO_P_W     = COORD_W + W_LO_W + 1;
    localparam int HI_P_W     = COORD_W + W_HI_W + 1;
    localparam int ACC_W      = COORD_W + WEIGHT_W + 1;
    localparam int Q_W        = ACC_W - FRAC_SHIFT;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_SHIFT;
    localparam logic [ACC_W-1:0]    RND_HALF   = ACC_W'(1) << (FRAC_SHIFT - 1);

    // command codes carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // input tdata layout, lowest bit first
    localparam int IDX_LSB    = 0;
    localparam int X_LSB      = IDX_LSB + IDX_W;
    localparam int Y_LSB      = X_LSB + COORD_W;
    localparam int Z_LSB      = Y_LSB + COORD_W;
    localparam int U_LSB      = Z_LSB + COORD_W;
    localparam int IN_FIELD_W = U_LSB + U_W;
    localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_FIELD_W = NUM_AXES * COORD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic signed [COORD_W-1:0] coord_t;

    // one classified item between front and back
    typedef struct packed {
        logic             is_eval;
        logic [IDX_W-1:0] idx;
        coord_t           load_x;
        coord_t           load_y;
        coord_t           load_z;
        logic [U_W-1:0]   u;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } q_wr_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_rd_t;

endpackage

`default_nettype wire

// ===== src/cbpe_front.sv =====
// ----------------------------------------------------------------------------
// cbpe_front
// accepts input transfers, decodes the command and clamps u to 1.0
// ----------------------------------------------------------------------------
`default_nettype none

module cbpe_front (
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [cbpe_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [0:0]                       s_tuser,
    input  wire logic                             q_full,
    output cbpe_pkg::q_wr_t                       q_wr
);

    logic [cbpe_pkg::U_W-1:0] u_raw;

    assign u_raw    = s_tdata[cbpe_pkg::U_LSB +: cbpe_pkg::U_W];
    assign s_tready = !q_full;

    always_comb begin
        q_wr.push         = s_tvalid && !q_full;
        q_wr.entry.is_eval = (s_tuser[0] == cbpe_pkg::CMD_EVAL);
        q_wr.entry.idx    = s_tdata[cbpe_pkg::IDX_LSB +: cbpe_pkg::IDX_W];
        q_wr.entry.load_x = s_tdata[cbpe_pkg::X_LSB +: cbpe_pkg::COORD_W];
        q_wr.entry.load_y = s_tdata[cbpe_pkg::Y_LSB +: cbpe_pkg::COORD_W];
        q_wr.entry.load_z = s_tdata[cbpe_pkg::Z_LSB +: cbpe_pkg::COORD_W];
        // anything above one counts as one
        q_wr.entry.u      = (u_raw > cbpe_pkg::U_ONE) ? cbpe_pkg::U_ONE : u_raw;
    end

endmodule

`default_nettype wire

// ===== src/cbpe_queue.sv =====
// ----------------------------------------------------------------------------
// cbpe_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cbpe_queue #(
    parameter int DEPTH = cbpe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cbpe_pkg::q_wr_t  q_wr,
    output logic                  q_full,
    output cbpe_pkg::q_rd_t       q_rd,
    input  wire logic             q_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbpe_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign q_full      = (count_reg == CNT_W'(DEPTH));
    assign q_rd.valid  = (count_reg != '0);
    assign q_rd.entry  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (q_wr.push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!q_wr.push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            mem_reg[wr_ptr_reg] <= q_wr.entry;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_wr.push && q_full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (count_reg != '0))
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== src/cbpe_back.sv =====
// ----------------------------------------------------------------------------
// cbpe_back
// control point store, weight pipeline, multiply-accumulate, rounding and
// output register
// ----------------------------------------------------------------------------
`default_nettype none

module cbpe_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cbpe_pkg::q_rd_t                   q_rd,
    output logic                                   q_pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [cbpe_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    localparam int NA = cbpe_pkg::NUM_AXES;
    localparam int NP = cbpe_pkg::NUM_POINTS;
    localparam int WS_W = cbpe_pkg::WEIGHT_W + 2;

    localparam logic signed [cbpe_pkg::Q_W-1:0] Q_MAX =
        cbpe_pkg::Q_W'($signed({1'b0, {(cbpe_pkg::COORD_W-1){1'b1}}}));
    localparam logic signed [cbpe_pkg::Q_W-1:0] Q_MIN =
        cbpe_pkg::Q_W'($signed({1'b1, {(cbpe_pkg::COORD_W-1){1'b0}}}));

    // control point store, axis by point
    cbpe_pkg::coord_t store_reg [NA][NP];

    logic adv;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg, m_tvalid_reg;

    // stage 1: u, v and their triples, snapshot of the points
    logic [cbpe_pkg::U_W-1:0]  s1_u_reg, s1_v_reg;
    logic [cbpe_pkg::U3_W-1:0] s1_u3_reg, s1_v3_reg;
    cbpe_pkg::coord_t          s1_pt_reg [NA][NP];
    // stage 2: squares
    logic [cbpe_pkg::SQ_W-1:0] s2_uu_reg, s2_vv_reg;
    logic [cbpe_pkg::U_W-1:0]  s2_u_reg, s2_v_reg;
    logic [cbpe_pkg::U3_W-1:0] s2_u3_reg, s2_v3_reg;
    cbpe_pkg::coord_t          s2_pt_reg [NA][NP];
    // stage 3: weights
    logic [cbpe_pkg::WEIGHT_W-1:0] s3_w_reg [NP];
    cbpe_pkg::coord_t              s3_pt_reg [NA][NP];
    // stage 4: partial products
    logic signed [cbpe_pkg::LO_P_W-1:0] s4_lo_reg [NA][NP];
    logic signed [cbpe_pkg::HI_P_W-1:0] s4_hi_reg [NA][NP];
    // stage 5 to 7: terms, pair sums, rounded total
    logic signed [cbpe_pkg::ACC_W-1:0] s5_t_reg [NA][NP];
    logic signed [cbpe_pkg::ACC_W-1:0] s6_a_reg [NA];
    logic signed [cbpe_pkg::ACC_W-1:0] s6_b_reg [NA];
    logic signed [cbpe_pkg::ACC_W-1:0] s7_sum_reg [NA];

    logic signed [cbpe_pkg::Q_W-1:0] q_val [NA];
    logic [NA-1:0]                   sat_hit;
    cbpe_pkg::coord_t                res [NA];
    logic [cbpe_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign q_pop    = adv && q_rd.valid;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // round already added, drop the fraction and clamp
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            q_val[a] = s7_sum_reg[a][cbpe_pkg::ACC_W-1:cbpe_pkg::FRAC_SHIFT];
            sat_hit[a] = (q_val[a] > Q_MAX) || (q_val[a] < Q_MIN);
            if (q_val[a] > Q_MAX) begin
                res[a] = cbpe_pkg::COORD_W'(Q_MAX);
            end else if (q_val[a] < Q_MIN) begin
                res[a] = cbpe_pkg::COORD_W'(Q_MIN);
            end else begin
                res[a] = cbpe_pkg::COORD_W'(q_val[a]);
            end
        end
    end

    // control: store writes and stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NA; a++) begin
                for (int p = 0; p < NP; p++) begin
                    store_reg[a][p] <= '0;
                end
            end
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (q_pop && !q_rd.entry.is_eval) begin
                store_reg[0][q_rd.entry.idx] <= q_rd.entry.load_x;
                store_reg[1][q_rd.entry.idx] <= q_rd.entry.load_y;
                store_reg[2][q_rd.entry.idx] <= q_rd.entry.load_z;
            end
            if (adv) begin
                s1_valid_reg <= q_pop && q_rd.entry.is_eval;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
                s6_valid_reg <= s5_valid_reg;
                s7_valid_reg <= s6_valid_reg;
                m_tvalid_reg <= s7_valid_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_u_reg  <= q_rd.entry.u;
            s1_v_reg  <= cbpe_pkg::U_ONE - q_rd.entry.u;
            s1_u3_reg <= cbpe_pkg::U3_W'(q_rd.entry.u) * cbpe_pkg::U3_W'(3);
            s1_v3_reg <= cbpe_pkg::U3_W'(cbpe_pkg::U_ONE - q_rd.entry.u)
                         * cbpe_pkg::U3_W'(3);
            s1_pt_reg <= store_reg;

            s2_uu_reg <= cbpe_pkg::SQ_W'(s1_u_reg) * cbpe_pkg::SQ_W'(s1_u_reg);
            s2_vv_reg <= cbpe_pkg::SQ_W'(s1_v_reg) * cbpe_pkg::SQ_W'(s1_v_reg);
            s2_u_reg  <= s1_u_reg;
            s2_v_reg  <= s1_v_reg;
            s2_u3_reg <= s1_u3_reg;
            s2_v3_reg <= s1_v3_reg;
            s2_pt_reg <= s1_pt_reg;

            // u^3, 3u^2 v, 3u v^2, v^3
            s3_w_reg[0] <= cbpe_pkg::WEIGHT_W'(s2_uu_reg) * cbpe_pkg::WEIGHT_W'(s2_u_reg);
            s3_w_reg[1] <= cbpe_pkg::WEIGHT_W'(s2_uu_reg) * cbpe_pkg::WEIGHT_W'(s2_v3_reg);
            s3_w_reg[2] <= cbpe_pkg::WEIGHT_W'(s2_vv_reg) * cbpe_pkg::WEIGHT_W'(s2_u3_reg);
            s3_w_reg[3] <= cbpe_pkg::WEIGHT_W'(s2_vv_reg) * cbpe_pkg::WEIGHT_W'(s2_v_reg);
            s3_pt_reg   <= s2_pt_reg;

            for (int a = 0; a < NA; a++) begin
                for (int p = 0; p < NP; p++) begin
                    s4_lo_reg[a][p] <= cbpe_pkg::LO_P_W'(s3_pt_reg[a][p])
                        * cbpe_pkg::LO_P_W'($signed({1'b0,
                              s3_w_reg[p][cbpe_pkg::W_LO_W-1:0]}));
                    s4_hi_reg[a][p] <= cbpe_pkg::HI_P_W'(s3_pt_reg[a][p])
                        * cbpe_pkg::HI_P_W'($signed({1'b0,
                              s3_w_reg[p][cbpe_pkg::WEIGHT_W-1:cbpe_pkg::W_LO_W]}));
                    s5_t_reg[a][p] <= (cbpe_pkg::ACC_W'(s4_hi_reg[a][p]) <<< cbpe_pkg::W_LO_W)
                        + cbpe_pkg::ACC_W'(s4_lo_reg[a][p]);
                end
                s6_a_reg[a]   <= s5_t_reg[a][0] + s5_t_reg[a][1];
                s6_b_reg[a]   <= s5_t_reg[a][2] + s5_t_reg[a][3];
                s7_sum_reg[a] <= s6_a_reg[a] + s6_b_reg[a] + $signed(cbpe_pkg::RND_HALF);
            end

            if (s7_valid_reg) begin
                m_tdata_reg <= cbpe_pkg::OUT_TDATA_W'({res[2], res[1], res[0]});
            end
        end
    end

    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_rd.entry.is_eval) |=>
            (store_reg[0][$past(q_rd.entry.idx)] == $past(q_rd.entry.load_x)) &&
            (store_reg[2][$past(q_rd.entry.idx)] == $past(q_rd.entry.load_z)))
        else $error("control point load not stored");

    a_weight_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (WS_W'(s3_w_reg[0]) + WS_W'(s3_w_reg[1]) + WS_W'(s3_w_reg[2])
                          + WS_W'(s3_w_reg[3])) == WS_W'(cbpe_pkg::WEIGHT_ONE))
        else $error("bezier weights do not sum to one");

    a_no_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s7_valid_reg) |-> (sat_hit == '0))
        else $error("curve point left the control hull");

endmodule

`default_nettype wire

// ===== src/cubic_bezier_point_eval_top.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_top
// cubic bezier curve point evaluator in three dimensions
// ----------------------------------------------------------------------------
// A load transfer (tuser cmd = 0) writes control point point_index with
// x, y, z in signed Q16.16; an evaluate transfer (cmd = 1) carries u in
// Q0.16 (65536 is 1.0, larger values count as 1.0) and returns one point
// sum(P_i * w_i) with w = u^3, 3u^2(1-u), 3u(1-u)^2, (1-u)^3 for points
// 0..3, rounded to nearest (ties upward). Loads return nothing. All
// control points are zero after reset. The block takes one transfer per
// clock: the front stores it into a four-entry queue whenever that queue
// has room, and the back pops one entry per clock, while its output
// register is not held, into an eight-stage multiplier pipeline (u/v,
// squares, weights, split partial products, terms, pair sums, rounded
// total, output register). A held output register stalls the back, and
// the queue then absorbs up to four further input transfers before
// tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_eval_top #(
    parameter int QUEUE_DEPTH = cbpe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [1:0] point_index, [33:2] load_x, [65:34] load_y, [97:66] load_z,
    // [114:98] param_u, rest zero
    input  wire logic [cbpe_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [0] cmd: 0 load control point, 1 evaluate
    input  wire logic [0:0]                        s_tuser,
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] curve_x, [63:32] curve_y, [95:64] curve_z
    output logic [cbpe_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    cbpe_pkg::q_wr_t q_wr;
    cbpe_pkg::q_rd_t q_rd;
    logic            q_full;
    logic            q_pop;

    // front: decode and clamp, push into the queue
    cbpe_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    // queue lets front and back stall independently
    cbpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_rd    (q_rd),
        .q_pop   (q_pop)
    );

    // back: store, weights, multiply-accumulate, output register
    cbpe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rd     (q_rd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
